### rtl/core/hrhp_pkg.sv
// Package for the HTTP response head parser.
// Holds the parse phase and release state types, event codes and the
// decoder interface structs; no dependencies.
`default_nettype none

package hrhp_pkg;

  localparam int KLEN_W = 5;
  localparam int STATUS_W = 16;
  localparam int LIMIT_W = 17;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;
  localparam logic [STATUS_W-1:0] STATUS_DEFAULT = 16'd200;
  localparam logic [STATUS_W-1:0] STATUS_MAX = 16'hFFFF;

  localparam int VERSION_LEN = 6;
  localparam logic [7:0] VERSION_WORD [VERSION_LEN] = '{"H", "T", "T", "P", "/", "1"};

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_STATUS = 3'd1;
  localparam logic [2:0] EV_KEYB = 3'd2;
  localparam logic [2:0] EV_KEYEND = 3'd3;
  localparam logic [2:0] EV_VALB = 3'd4;
  localparam logic [2:0] EV_VALEND = 3'd5;
  localparam logic [2:0] EV_DONE = 3'd6;
  localparam logic [2:0] EV_ERROR = 3'd7;

  typedef enum logic [8:0] {
    PH_VERSION  = 9'b000000001,
    PH_MINOR    = 9'b000000010,
    PH_STATUS   = 9'b000000100,
    PH_REASON   = 9'b000001000,
    PH_KEY      = 9'b000010000,
    PH_SKIPSP   = 9'b000100000,
    PH_VALUE    = 9'b001000000,
    PH_CR_LF    = 9'b010000000,
    PH_FINAL_LF = 9'b100000000
  } phase_t;

  typedef enum logic [3:0] {
    R_IDLE   = 4'b0001,
    R_READ   = 4'b0010,
    R_KEYB   = 4'b0100,
    R_KEYEND = 4'b1000
  } rel_state_t;

  typedef struct packed {
    phase_t                phase;
    logic [STATUS_W-1:0]   status;
    logic                  minor_seen;
    logic                  prefix_ok;
    logic                  key_empty;
    logic                  key_six;
    logic                  key_full;
    logic                  over_limit;
  } ctx_t;

  typedef struct packed {
    phase_t                phase_next;
    logic [STATUS_W-1:0]   status_next;
    logic                  minor_seen_next;
    logic                  store;
    logic                  release_key;
    logic                  clear_count;
    logic                  restart;
    logic [2:0]            event_code;
    logic [7:0]            out_byte;
    logic [STATUS_W-1:0]   status_out;
  } step_t;

endpackage

`default_nettype wire

### rtl/core/hrhp_decode.sv
// Per-byte decoder of the HTTP response head parser.
// Maps one head byte and the current parse context to the next context,
// the key store action and the event; depends on hrhp_pkg.
`default_nettype none

module hrhp_decode
  import hrhp_pkg::*;
(
  input  wire logic [7:0] data_byte,
  input  wire ctx_t       ctx,
  output step_t           step
);

  logic                is_digit;
  logic                is_key_char;
  logic                err;
  logic [19:0]         status_mul;
  logic [STATUS_W-1:0] status_sat;

  assign is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
  assign is_key_char = ((data_byte >= 8'h41) && (data_byte <= 8'h5A)) ||
                       ((data_byte >= 8'h61) && (data_byte <= 8'h7A)) ||
                       is_digit || (data_byte == CH_DASH) || (data_byte == CH_UNDER);

  assign status_mul = ({4'b0, ctx.status} << 3) + ({4'b0, ctx.status} << 1) +
                      {16'b0, data_byte[3:0]};
  assign status_sat = (status_mul[19:16] != 4'b0) ? STATUS_MAX : status_mul[15:0];

  always_comb begin
    step.phase_next      = ctx.phase;
    step.status_next     = ctx.status;
    step.minor_seen_next = ctx.minor_seen;
    step.store           = 1'b0;
    step.release_key     = 1'b0;
    step.clear_count     = 1'b0;
    step.restart         = 1'b0;
    step.event_code      = EV_NONE;
    step.out_byte        = 8'h00;
    step.status_out      = '0;
    err                  = 1'b0;

    if (ctx.over_limit) begin
      err = 1'b1;
    end else begin
      unique case (ctx.phase)
        PH_VERSION: begin
          if (data_byte == CH_DOT) begin
            if (ctx.key_six && ctx.prefix_ok) begin
              step.clear_count = 1'b1;
              step.phase_next  = PH_MINOR;
            end else begin
              err = 1'b1;
            end
          end else if (data_byte == CH_COLON) begin
            step.event_code  = EV_STATUS;
            step.status_out  = STATUS_DEFAULT;
            step.release_key = 1'b1;
            step.phase_next  = PH_SKIPSP;
          end else if (is_key_char || data_byte == CH_SLASH) begin
            if (ctx.key_full) err = 1'b1;
            else step.store = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
        PH_MINOR: begin
          if (data_byte == CH_SPACE) begin
            step.phase_next = PH_STATUS;
          end else if ((data_byte == 8'h30 || data_byte == 8'h31) && !ctx.minor_seen) begin
            step.minor_seen_next = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
        PH_STATUS: begin
          if (data_byte == CH_SPACE) begin
            step.event_code = EV_STATUS;
            step.status_out = ctx.status;
            step.phase_next = PH_REASON;
          end else if (is_digit) begin
            step.status_next = status_sat;
          end else begin
            err = 1'b1;
          end
        end
        PH_REASON: begin
          if (data_byte == CH_LF) step.phase_next = PH_KEY;
          else if (data_byte == CH_CR) step.phase_next = PH_CR_LF;
        end
        PH_KEY: begin
          if (data_byte == CH_COLON) begin
            step.release_key = 1'b1;
            step.phase_next  = PH_SKIPSP;
          end else if (ctx.key_empty && data_byte == CH_LF) begin
            step.event_code = EV_DONE;
            step.restart    = 1'b1;
          end else if (ctx.key_empty && data_byte == CH_CR) begin
            step.phase_next = PH_FINAL_LF;
          end else if (is_key_char) begin
            if (ctx.key_full) err = 1'b1;
            else step.store = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
        PH_SKIPSP: begin
          if (data_byte != CH_SPACE) begin
            step.event_code = EV_VALB;
            step.out_byte   = data_byte;
            step.phase_next = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (data_byte >= CH_SPACE) begin
            step.event_code = EV_VALB;
            step.out_byte   = data_byte;
          end else if (data_byte == CH_LF || data_byte == CH_CR) begin
            step.event_code = EV_VALEND;
            step.phase_next = (data_byte == CH_CR) ? PH_CR_LF : PH_KEY;
          end else begin
            err = 1'b1;
          end
        end
        PH_CR_LF: begin
          if (data_byte == CH_LF) begin
            step.clear_count = 1'b1;
            step.phase_next  = PH_KEY;
          end else begin
            err = 1'b1;
          end
        end
        PH_FINAL_LF: begin
          if (data_byte == CH_LF) begin
            step.event_code = EV_DONE;
            step.restart    = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
        default: err = 1'b1;
      endcase
    end

    if (err) begin
      step.event_code  = EV_ERROR;
      step.out_byte    = 8'h00;
      step.status_out  = '0;
      step.store       = 1'b0;
      step.release_key = 1'b0;
      step.restart     = 1'b1;
    end

    if (step.restart) begin
      step.phase_next      = PH_VERSION;
      step.status_next     = '0;
      step.minor_seen_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/http_response_head_parser.sv
// A byte's own result request is offered in the cycle after it is accepted.
// One byte per cycle while results are taken and no key is being released.
// A colon releases the buffered key from the key memory: states R_READ (the
// registered read) and R_KEYB per key byte, then R_KEYEND for the key end.
// Reset (synchronous): parse state restarts at the version word, limit 65536;
// the key memory is not cleared.
`default_nettype none

module http_response_head_parser
  import hrhp_pkg::*;
#(
  parameter int KEY_DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_data,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [7:0]         data_byte,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [2:0]         event_res,
  output      logic [7:0]         out_byte,
  output      logic [STATUS_W-1:0] status_code,
  output      logic [KLEN_W-1:0]  key_length,
  output      logic               last
);

  localparam int CW = $clog2(KEY_DEPTH);

  logic [LIMIT_W-1:0]  max_head_bytes;
  logic [LIMIT_W-1:0]  head_byte_count;
  phase_t              phase;
  logic [STATUS_W-1:0] status_accum;
  logic                minor_digit_seen;
  logic                prefix_ok;
  logic [CW-1:0]       key_count;
  logic [CW-1:0]       rel_idx;
  logic [CW-1:0]       rel_idx_next;
  rel_state_t          rel_state;
  logic [7:0]          key_mem [KEY_DEPTH];
  logic [7:0]          rd_data;

  ctx_t                ctx;
  step_t               step;
  logic                accept;
  logic                slot_free;
  logic                load;
  logic [2:0]          ld_event;
  logic [7:0]          ld_byte;
  logic [STATUS_W-1:0] ld_status;
  logic [KLEN_W-1:0]   ld_klen;
  logic                ld_last;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (rel_state == R_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;

  assign ctx.phase      = phase;
  assign ctx.status     = status_accum;
  assign ctx.minor_seen = minor_digit_seen;
  assign ctx.prefix_ok  = prefix_ok;
  assign ctx.key_empty  = (key_count == '0);
  assign ctx.key_six    = (key_count == CW'(VERSION_LEN));
  assign ctx.key_full   = (key_count >= CW'(KEY_DEPTH - 1));
  assign ctx.over_limit = (head_byte_count >= max_head_bytes);

  hrhp_decode u_decode (
    .data_byte (data_byte),
    .ctx       (ctx),
    .step      (step)
  );

  assign rel_idx_next = rel_idx + 1'b1;

  always_comb begin
    load      = 1'b0;
    ld_event  = EV_NONE;
    ld_byte   = 8'h00;
    ld_status = '0;
    ld_klen   = '0;
    ld_last   = 1'b0;
    unique case (rel_state)
      R_IDLE: begin
        if (accept && (!step.release_key || step.event_code == EV_STATUS)) begin
          load      = 1'b1;
          ld_event  = step.event_code;
          ld_byte   = step.out_byte;
          ld_status = step.status_out;
          ld_last   = !step.release_key;
        end
      end
      R_KEYB: begin
        if (slot_free) begin
          load     = 1'b1;
          ld_event = EV_KEYB;
          ld_byte  = rd_data;
        end
      end
      R_KEYEND: begin
        if (slot_free) begin
          load     = 1'b1;
          ld_event = EV_KEYEND;
          ld_klen  = KLEN_W'(key_count);
          ld_last  = 1'b1;
        end
      end
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (step.store && accept) begin
      key_mem[key_count] <= data_byte;
    end
    rd_data <= key_mem[rel_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_head_bytes <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_head_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_VERSION;
      status_accum     <= '0;
      minor_digit_seen <= 1'b0;
      head_byte_count  <= '0;
      key_count        <= '0;
      prefix_ok        <= 1'b1;
      rel_idx          <= '0;
      rel_state        <= R_IDLE;
    end else begin
      unique case (rel_state)
        R_IDLE: begin
          if (accept) begin
            phase            <= step.phase_next;
            status_accum     <= step.status_next;
            minor_digit_seen <= step.minor_seen_next;
            if (step.restart) begin
              head_byte_count <= '0;
              key_count       <= '0;
              prefix_ok       <= 1'b1;
            end else begin
              if (!ctx.over_limit) head_byte_count <= head_byte_count + 1'b1;
              if (step.clear_count) begin
                key_count <= '0;
              end else if (step.store) begin
                key_count <= key_count + 1'b1;
                if (key_count < CW'(VERSION_LEN)) begin
                  prefix_ok <= prefix_ok && (data_byte == VERSION_WORD[key_count[2:0]]);
                end
              end
            end
            if (step.release_key) begin
              rel_idx   <= '0;
              rel_state <= (key_count == '0) ? R_KEYEND : R_READ;
            end
          end
        end
        R_READ: rel_state <= R_KEYB;
        R_KEYB: begin
          if (slot_free) begin
            rel_idx   <= rel_idx_next;
            rel_state <= (rel_idx_next == key_count) ? R_KEYEND : R_READ;
          end
        end
        R_KEYEND: begin
          if (slot_free) begin
            key_count <= '0;
            rel_state <= R_IDLE;
          end
        end
        default: rel_state <= R_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_res   <= ld_event;
      out_byte    <= ld_byte;
      status_code <= ld_status;
      key_length  <= ld_klen;
      last        <= ld_last;
    end
  end

  a_rel_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (rel_state == R_KEYB || rel_state == R_READ) |-> (rel_idx < key_count))
    else $error("key release index past key count");

  a_key_count_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= CW'(KEY_DEPTH - 1))
    else $error("key count beyond key memory");

  a_keyend_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_KEYEND) |-> last)
    else $error("key end request not marked last");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && step.restart) |=> (phase == PH_VERSION && key_count == '0 &&
                                  head_byte_count == '0))
    else $error("restart did not clear parse state");

  a_no_accept_in_release: assert property (@(posedge clk) disable iff (rst)
    (rel_state == R_READ || rel_state == R_KEYB) |-> !in_ready)
    else $error("input taken during key release");

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking bench for http_response_head_parser: byte requests in, event results out.
// Holds a scoreboard class that predicts each event and compares it with the block's output.
// Depends on hrhp_pkg for widths, event codes, parse phases and character constants.
module tb
  import hrhp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_DEPTH = 32;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_GAP = 80;
  localparam string KEY_CHARS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  typedef struct packed {
    logic [2:0]          ev;
    logic [7:0]          data;
    logic [STATUS_W-1:0] status;
    logic [KLEN_W-1:0]   klen;
    logic                is_last;
  } head_result_t;

  class head_scoreboard;
    int limit;
    phase_t parse_state;
    logic [7:0] key_buf [KEY_DEPTH];
    int key_cnt;
    int status_acc;
    int byte_cnt;
    bit minor_seen;
    head_result_t step_q[$];
    head_result_t expected_q[$];
    int mismatches;

    function new();
      limit = LIMIT_RESET;
      mismatches = 0;
      restart_head();
    endfunction

    function void restart_head();
      parse_state = PH_VERSION;
      key_cnt = 0;
      status_acc = 0;
      byte_cnt = 0;
      minor_seen = 1'b0;
    endfunction

    function void add(logic [2:0] ev, logic [7:0] data, logic [STATUS_W-1:0] status,
                      logic [KLEN_W-1:0] klen);
      head_result_t r;
      r.ev = ev;
      r.data = data;
      r.status = status;
      r.klen = klen;
      r.is_last = 1'b0;
      step_q.insert(step_q.size(), r);
    endfunction

    function bit is_key_char(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
             (c >= "0" && c <= "9") || c == CH_DASH || c == CH_UNDER;
    endfunction

    function bit store_key(logic [7:0] c);
      if (key_cnt >= KEY_DEPTH - 1) return 1'b0;
      key_buf[key_cnt] = c;
      key_cnt++;
      return 1'b1;
    endfunction

    function void release_key();
      for (int k = 0; k < key_cnt; k++) add(EV_KEYB, key_buf[k], '0, '0);
      add(EV_KEYEND, '0, '0, KLEN_W'(key_cnt));
      key_cnt = 0;
      parse_state = PH_SKIPSP;
    endfunction

    function void note_byte(logic [7:0] c);
      bit err;
      bit prefix_ok;
      step_q.delete();
      err = 1'b0;
      if (byte_cnt >= limit) begin
        err = 1'b1;
      end else begin
        byte_cnt++;
        case (parse_state)
          PH_VERSION: begin
            if (c == CH_DOT) begin
              prefix_ok = (key_cnt == VERSION_LEN);
              if (prefix_ok)
                for (int i = 0; i < VERSION_LEN; i++)
                  if (key_buf[i] != VERSION_WORD[i]) prefix_ok = 1'b0;
              if (prefix_ok) begin
                key_cnt = 0;
                parse_state = PH_MINOR;
              end else begin
                err = 1'b1;
              end
            end else if (c == CH_COLON) begin
              add(EV_STATUS, '0, STATUS_DEFAULT, '0);
              release_key();
            end else if (is_key_char(c) || c == CH_SLASH) begin
              err = !store_key(c);
            end else begin
              err = 1'b1;
            end
          end
          PH_MINOR: begin
            if (c == CH_SPACE) parse_state = PH_STATUS;
            else if ((c == "0" || c == "1") && !minor_seen) minor_seen = 1'b1;
            else err = 1'b1;
          end
          PH_STATUS: begin
            if (c == CH_SPACE) begin
              add(EV_STATUS, '0, STATUS_W'(status_acc), '0);
              parse_state = PH_REASON;
            end else if (c >= "0" && c <= "9") begin
              status_acc = status_acc * 10 + int'(c - "0");
              if (status_acc > int'(STATUS_MAX)) status_acc = int'(STATUS_MAX);
            end else begin
              err = 1'b1;
            end
          end
          PH_REASON: begin
            if (c == CH_LF) parse_state = PH_KEY;
            else if (c == CH_CR) parse_state = PH_CR_LF;
          end
          PH_KEY: begin
            if (c == CH_COLON) begin
              release_key();
            end else if (key_cnt == 0 && c == CH_LF) begin
              add(EV_DONE, '0, '0, '0);
              restart_head();
            end else if (key_cnt == 0 && c == CH_CR) begin
              parse_state = PH_FINAL_LF;
            end else if (is_key_char(c)) begin
              err = !store_key(c);
            end else begin
              err = 1'b1;
            end
          end
          PH_SKIPSP: begin
            if (c != CH_SPACE) begin
              add(EV_VALB, c, '0, '0);
              parse_state = PH_VALUE;
            end
          end
          PH_VALUE: begin
            if (c >= CH_SPACE) begin
              add(EV_VALB, c, '0, '0);
            end else if (c == CH_LF || c == CH_CR) begin
              add(EV_VALEND, '0, '0, '0);
              parse_state = (c == CH_CR) ? PH_CR_LF : PH_KEY;
            end else begin
              err = 1'b1;
            end
          end
          PH_CR_LF: begin
            if (c == CH_LF) begin
              key_cnt = 0;
              parse_state = PH_KEY;
            end else begin
              err = 1'b1;
            end
          end
          PH_FINAL_LF: begin
            if (c == CH_LF) begin
              add(EV_DONE, '0, '0, '0);
              restart_head();
            end else begin
              err = 1'b1;
            end
          end
          default: err = 1'b1;
        endcase
      end
      if (err) begin
        step_q.delete();
        add(EV_ERROR, '0, '0, '0);
        restart_head();
      end
      if (step_q.size() == 0) add(EV_NONE, '0, '0, '0);
      step_q[step_q.size() - 1].is_last = 1'b1;
      foreach (step_q[i]) expected_q.insert(expected_q.size(), step_q[i]);
    endfunction

    function void check_result(head_result_t got);
      head_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ev=%0d byte=%02h status=%0d klen=%0d last=%0d",
                   got.ev, got.data, got.status, got.klen, got.is_last);
        return;
      end
      want = expected_q.pop_front();
      if (got.ev !== want.ev || got.data !== want.data || got.status !== want.status ||
          got.klen !== want.klen || got.is_last !== want.is_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected ev=%0d byte=%02h status=%0d klen=%0d last=%0d,",
                    " got ev=%0d byte=%02h status=%0d klen=%0d last=%0d"},
                   want.ev, want.data, want.status, want.klen, want.is_last,
                   got.ev, got.data, got.status, got.klen, got.is_last);
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] data_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] event_res;
  logic [7:0] out_byte;
  logic [STATUS_W-1:0] status_code;
  logic [KLEN_W-1:0] key_length;
  logic last;

  head_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int cycle_count = 0;
  logic [7:0] stream_q[$];

  http_response_head_parser #(.KEY_DEPTH(KEY_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_res(event_res),
    .out_byte(out_byte),
    .status_code(status_code),
    .key_length(key_length),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    head_result_t got;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got.ev = event_res;
      got.data = out_byte;
      got.status = status_code;
      got.klen = key_length;
      got.is_last = last;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("http_response_head_parser regression: fail");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // hold off new requests until every expected result is back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.limit = int'(value);
  endtask

  function void put_byte(logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
  endfunction

  function void push_line_end();
    if ($urandom_range(0, 1)) put_byte(CH_CR);
    put_byte(CH_LF);
  endfunction

  function void push_key(int n);
    for (int i = 0; i < n; i++)
      put_byte(KEY_CHARS[$urandom_range(0, KEY_CHARS.len() - 1)]);
  endfunction

  function void push_field();
    int len;
    if ($urandom_range(0, 9) == 0) len = $urandom_range(29, 32);
    else len = $urandom_range(0, 6);
    push_key(len);
    put_byte(CH_COLON);
    repeat ($urandom_range(0, 2)) put_byte(CH_SPACE);
    repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(32, 255)));
    push_line_end();
  endfunction

  function void build_head();
    int n_fields;
    int minor;
    logic [7:0] b;
    stream_q.delete();
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) == 0) begin
      push_key($urandom_range(0, 4));
      put_byte(CH_COLON);
      repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(32, 255)));
      push_line_end();
      n_fields = $urandom_range(0, 2);
    end else begin
      for (int i = 0; i < VERSION_LEN; i++) put_byte(VERSION_WORD[i]);
      put_byte(CH_DOT);
      minor = $urandom_range(0, 7);
      if (minor >= 3 && minor <= 4) put_byte("0");
      else if (minor >= 5) put_byte("1");
      if (minor == 7) put_byte("1");
      put_byte(CH_SPACE);
      repeat ($urandom_range(0, 6)) put_byte(8'("0" + $urandom_range(0, 9)));
      put_byte(CH_SPACE);
      repeat ($urandom_range(0, 4)) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_CR || b == CH_LF) b = CH_SPACE;
        put_byte(b);
      end
      push_line_end();
      n_fields = $urandom_range(0, 3);
    end
    repeat (n_fields) push_field();
    push_line_end();
    if ($urandom_range(0, 4) == 0)
      stream_q[$urandom_range(0, stream_q.size() - 1)] = 8'($urandom_range(0, 255));
  endfunction

  task automatic run_random(input int quota);
    int start;
    start = items_sent;
    while (items_sent - start < quota) begin
      build_head();
      foreach (stream_q[i])
        if (items_sent - start < quota) send_byte(stream_q[i]);
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_limit(LIMIT_RESET);
    set_idling(0, 0);
    send_text(":");
    send_byte(8'h00);
    send_byte(CH_LF);
    send_byte(CH_LF);
    send_text("HTTP/1. 99999 ");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_text("X.");
    send_byte(8'hFF);
    wait_drain();

    write_limit(LIMIT_W'(1));
    set_idling(68, 0);
    run_random(16);
    wait_drain();

    write_limit(LIMIT_W'($urandom_range(12, 40)));
    set_idling(0, 68);
    run_random(56);
    wait_drain();

    write_limit(LIMIT_W'($urandom_range(100, 65535)));
    set_idling(6, 6);
    run_random(50);
    wait_drain();
    run_random(50);
    wait_drain();

    write_limit(LIMIT_RESET);
    set_idling(0, 0);
    run_random(24);
    wait_drain();

    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("http_response_head_parser regression: pass");
    else
      $display("http_response_head_parser regression: fail");
    $finish;
  end

endmodule
